>>> hw/rtl/spq_pkg.sv
package spq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int VAL_W = 32;
  localparam int PRI_W = 8;
  localparam int OCC_W = 5;

  localparam logic [1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [1:0] CMD_DEQUEUE = 2'd1;
  localparam logic [1:0] CMD_PEEK    = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] value;
    logic        [PRI_W-1:0] priority_req;
  } entry_t;

  typedef struct packed {
    logic                    enq;
    logic                    deq;
    logic signed [VAL_W-1:0] value;
    logic        [PRI_W-1:0] priority_req;
  } cell_ctl_t;

endpackage

>>> hw/rtl/spq_if.sv
interface spq_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        command;
  logic signed [spq_pkg::VAL_W-1:0]  value;
  logic        [spq_pkg::PRI_W-1:0]  priority_req;

  modport source (output valid, output command, output value, output priority_req,
                  input ready);
  modport sink (input valid, input command, input value, input priority_req,
                output ready);
endinterface

interface spq_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [spq_pkg::VAL_W-1:0]  head_value;
  logic [1:0]                        status;
  logic [spq_pkg::OCC_W-1:0]         occupancy;

  modport source (output valid, output head_value, output status, output occupancy,
                  input ready);
  modport sink (input valid, input head_value, input status, input occupancy,
                output ready);
endinterface

>>> hw/rtl/sorted_priority_queue.sv
// Channel   Dir  Payload                               Handshake
// in_ch     in   command, value, priority_req          valid/ready
// out_ch    out  head_value, status, occupancy         valid/ready
//
// One request per cycle unless a stalled result blocks it; its result appears in the output register in the next cycle.
// Every cell compares its priority with the new one in parallel and shifts in the same cycle.
// Synchronous active-low reset empties all cells at once.
// A stalled result holds and blocks the next request until taken.
module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  spq_pkg::entry_t    ent  [QUEUE_DEPTH];
  logic               open [QUEUE_DEPTH];
  spq_pkg::cell_ctl_t ctl;

  logic [CNT_W-1:0]                 count_r, count_nxt;
  logic                             out_valid_r;
  logic signed [spq_pkg::VAL_W-1:0] out_head_r, out_head_nxt;
  logic [1:0]                       out_status_r, out_status_nxt;
  logic [spq_pkg::OCC_W-1:0]        out_occ_r;
  logic                             take, full, empty;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign take  = in_ch.valid && in_ch.ready;
  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    ctl.enq          = 1'b0;
    ctl.deq          = 1'b0;
    ctl.value        = in_ch.value;
    ctl.priority_req = in_ch.priority_req;
    count_nxt        = count_r;
    out_head_nxt     = '0;
    out_status_nxt   = spq_pkg::ST_OK;
    if (take) begin
      unique case (in_ch.command)
        spq_pkg::CMD_ENQUEUE: begin
          if (full) begin
            out_status_nxt = spq_pkg::ST_FULL;
          end else begin
            ctl.enq   = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        spq_pkg::CMD_DEQUEUE, spq_pkg::CMD_PEEK: begin
          if (empty) begin
            out_status_nxt = spq_pkg::ST_EMPTY;
          end else begin
            out_head_nxt = ent[0].value;
            if (in_ch.command == spq_pkg::CMD_DEQUEUE) begin
              ctl.deq   = 1'b1;
              count_nxt = count_r - CNT_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spq_pkg::entry_t left_ent, right_ent;
    logic            left_open;
    if (i == 0) begin : g_first
      assign left_ent  = '0;
      assign left_open = 1'b0;
    end else begin : g_mid
      assign left_ent  = ent[i-1];
      assign left_open = open[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = ent[i+1];
    end
    spq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .left_ent  (left_ent),
      .left_open (left_open),
      .right_ent (right_ent),
      .ent       (ent[i]),
      .open      (open[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (take) begin
      out_head_r   <= out_head_nxt;
      out_status_r <= out_status_nxt;
      out_occ_r    <= spq_pkg::OCC_W'(count_nxt);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.head_value = out_head_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.occupancy  = out_occ_r;

endmodule

>>> hw/rtl/spq_cell.sv
module spq_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  spq_pkg::cell_ctl_t  ctl,
  input  spq_pkg::entry_t     left_ent,
  input  logic                left_open,
  input  spq_pkg::entry_t     right_ent,
  output spq_pkg::entry_t     ent,
  output logic                open
);

  logic                             valid_r, valid_nxt;
  logic signed [spq_pkg::VAL_W-1:0] value_r, value_nxt;
  logic        [spq_pkg::PRI_W-1:0] pri_r, pri_nxt;

  assign open = !valid_r || (pri_r < ctl.priority_req);
  assign ent  = '{valid: valid_r, value: value_r, priority_req: pri_r};

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    pri_nxt   = pri_r;
    if (ctl.enq && open) begin
      if (left_open) begin
        valid_nxt = left_ent.valid;
        value_nxt = left_ent.value;
        pri_nxt   = left_ent.priority_req;
      end else begin
        valid_nxt = 1'b1;
        value_nxt = ctl.value;
        pri_nxt   = ctl.priority_req;
      end
    end else if (ctl.deq) begin
      valid_nxt = right_ent.valid;
      value_nxt = right_ent.value;
      pri_nxt   = right_ent.priority_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    value_r <= value_nxt;
    pri_r   <= pri_nxt;
  end

endmodule
